FILE: rtl/sorted_discrete_histogram_macros.svh
// Assertion macros shared by the histogram RTL.
// Both macros expect signals named clk and arst_n in the using module.
`ifndef SORTED_DISCRETE_HISTOGRAM_MACROS_SVH
`define SORTED_DISCRETE_HISTOGRAM_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SDH_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SDH_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/sdh_pkg.sv
// Shared constants for the sorted discrete histogram.
// No dependencies; used by the channel interfaces and the top level.
package sdh_pkg;

	localparam int VAL_W  = 32;
	localparam int PROP_W = 17;
	localparam int SD_W   = 31;

	localparam logic [1:0] MODE_INSERT = 2'd0;
	localparam logic [1:0] MODE_REPORT = 2'd1;
	localparam logic [1:0] MODE_CLEAR  = 2'd2;

	localparam logic [1:0] KIND_ACK     = 2'd0;
	localparam logic [1:0] KIND_ENTRY   = 2'd1;
	localparam logic [1:0] KIND_SUMMARY = 2'd2;
	localparam logic [1:0] KIND_DROP    = 2'd3;

endpackage

FILE: rtl/sdh_if.sv
// Valid/ready channels for sample requests and histogram results.
// Depends on sdh_pkg for field widths.
interface sdh_sample_if import sdh_pkg::*;;
	logic                    valid;
	logic                    ready;
	logic [1:0]              mode;
	logic signed [VAL_W-1:0] sample_value;

	modport source (output valid, mode, sample_value, input ready);
	modport sink (input valid, mode, sample_value, output ready);
endinterface

interface sdh_result_if import sdh_pkg::*;;
	logic                    valid;
	logic                    ready;
	logic [1:0]              kind;
	logic signed [VAL_W-1:0] entry_value;
	logic [VAL_W-1:0]        count;
	logic [PROP_W-1:0]       proportion;
	logic signed [VAL_W-1:0] mean;
	logic [SD_W-1:0]         std_deviation;
	logic                    last;

	modport source (output valid, kind, entry_value, count, proportion, mean,
		std_deviation, last, input ready);
	modport sink (input valid, kind, entry_value, count, proportion, mean,
		std_deviation, last, output ready);
endinterface

FILE: rtl/sdh_div.sv
// Restoring divider, one quotient bit per cycle, for the histogram statistics.
// Standalone; instantiated by sorted_discrete_histogram.
module sdh_div #(
	parameter int NW = 104,
	parameter int DW = 38
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          done,
	output logic [NW-1:0] quot,
	output logic          rem_nz
);
	localparam int CW = $clog2(NW + 1);

	logic [NW-1:0] num_q;
	logic [NW-1:0] quot_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] den_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [DW:0]   shifted;
	logic [DW:0]   diff;
	logic          ge;

	assign shifted = {rem_q, num_q[NW-1]};
	assign diff    = shifted - {1'b0, den_q};
	assign ge      = shifted >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			num_q  <= '0;
			quot_q <= '0;
			rem_q  <= '0;
			den_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NW);
				num_q  <= num;
				den_q  <= den;
				rem_q  <= '0;
				quot_q <= '0;
			end else if (busy_q) begin
				rem_q  <= ge ? diff[DW-1:0] : shifted[DW-1:0];
				quot_q <= {quot_q[NW-2:0], ge};
				num_q  <= num_q << 1;
				cnt_q  <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done   = done_q;
	assign quot   = quot_q;
	assign rem_nz = |rem_q;
endmodule

FILE: rtl/sorted_discrete_histogram.sv
// Sorted discrete histogram: top level, needs sdh_pkg, sdh_if, sdh_div and the macros.
// Insert: linear search, then one shift per moved entry. Clear and the unused mode go
// straight to the acknowledgement. Report: a weighted-sum pass, a division and a result
// per entry, a spread pass, two more divisions and the square-root steps, with every
// division done on the bit-serial divider. One request at a time.
// Reset clears the entry count and sample total; the tables need no clearing pass.
`include "sorted_discrete_histogram_macros.svh"

module sorted_discrete_histogram import sdh_pkg::*; #(
	parameter int TABLE_DEPTH = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	sdh_sample_if.sink   sample_ch,
	sdh_result_if.source result_ch
);
	localparam int IDX_W = $clog2(TABLE_DEPTH + 1);
	localparam int AW    = $clog2(TABLE_DEPTH);
	localparam int WW    = VAL_W + IDX_W;
	localparam int ACC_W = 98 + IDX_W;

	typedef enum logic [4:0] {
		S_IDLE, S_SEARCH, S_SHIFT, S_ACK,
		S_SUM, S_SUM_ADD, S_ENT, S_ENT_WAIT, S_ENT_EMIT,
		S_MEAN, S_MEAN_WAIT, S_SQ, S_PLO, S_PHI, S_PACC,
		S_VAR, S_VAR_WAIT, S_SQRT, S_SUMMARY
	} state_t;

	state_t           state_q;
	logic [IDX_W-1:0] used_q, idx_q, pos_q, idx_m1;
	logic [31:0]      total_q, sample_q, vmin_q, mean_q;
	logic [1:0]       ack_kind_q;
	logic [WW-1:0]    weight_q;
	logic [ACC_W-1:0] acc_q;
	logic [65:0]      prod_q, sq_q;
	logic [63:0]      rad_q, res_q, bit_q;

	// Result register; the sequencer stalls only when it holds an untaken result.
	logic              res_valid_q, last_q;
	logic [1:0]        kind_q;
	logic [31:0]       entry_q, count_q, mean_out_q;
	logic [PROP_W-1:0] prop_q;
	logic [SD_W-1:0]   sd_q;

	// Entry tables: one combinational read port and one write port.
	logic [31:0] val_mem [TABLE_DEPTH];
	logic [31:0] cnt_mem [TABLE_DEPTH];
	logic [AW-1:0] rd_addr, wr_addr;
	logic [31:0]   rd_val, rd_cnt, wr_val, wr_cnt;
	logic          wr_en;

	logic             can_emit, emit_now;
	logic [32:0]      mul_a, mul_b, span, err, abs_err;
	logic [31:0]      vbase;
	logic [65:0]      mul_p;
	logic             div_start, div_done, div_rem_nz;
	logic [ACC_W-1:0] div_num, div_q;
	logic [34:0]      mean_sum, mean_fix;
	logic [63:0]      var_sat, trial;
	logic             is_last;

	assign idx_m1   = idx_q - IDX_W'(1);
	assign rd_addr  = (state_q == S_SHIFT) ? idx_m1[AW-1:0] : idx_q[AW-1:0];
	assign rd_val   = val_mem[rd_addr];
	assign rd_cnt   = cnt_mem[rd_addr];
	assign can_emit = !res_valid_q || result_ch.ready;
	// A new result is loaded this cycle; the taken one is replaced rather than cleared.
	assign emit_now = can_emit && (state_q == S_ACK || state_q == S_ENT_EMIT ||
		state_q == S_SUMMARY);
	assign is_last  = (idx_q + IDX_W'(1)) == used_q;

	// Table write side: count bumps, the shift toward the end, and new entries.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = idx_q[AW-1:0];
		wr_val  = rd_val;
		wr_cnt  = rd_cnt;
		if (state_q == S_SEARCH && idx_q < used_q && rd_val == sample_q) begin
			wr_en  = 1'b1;
			wr_cnt = (rd_cnt == '1) ? rd_cnt : rd_cnt + 32'd1;
		end else if (state_q == S_SHIFT) begin
			wr_en = 1'b1;
			if (idx_q == pos_q) begin
				wr_val = sample_q;
				wr_cnt = 32'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			val_mem[wr_addr] <= wr_val;
			cnt_mem[wr_addr] <= wr_cnt;
		end
	end

	// The one shared multiplier; every product is registered before use.
	assign vbase   = (idx_q == '0) ? rd_val : vmin_q;
	assign span    = {rd_val[31], rd_val} - {vbase[31], vbase};
	assign err     = {rd_val[31], rd_val} - {mean_q[31], mean_q};
	assign abs_err = err[32] ? (33'd0 - err) : err;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_SUM: begin
				mul_a = span;
				mul_b = {1'b0, rd_cnt};
			end
			S_SQ: begin
				mul_a = abs_err;
				mul_b = abs_err;
			end
			S_PLO: begin
				mul_a = prod_q[32:0];
				mul_b = {1'b0, rd_cnt};
			end
			S_PHI: begin
				mul_a = sq_q[65:33];
				mul_b = {1'b0, rd_cnt};
			end
			default: begin
			end
		endcase
	end
	assign mul_p = mul_a * mul_b;

	// Divider operands: proportions, then mean, then variance.
	assign div_start = (state_q == S_ENT) || (state_q == S_MEAN) || (state_q == S_VAR);
	assign div_num   = (state_q == S_ENT) ? ACC_W'({rd_cnt, 16'd0}) : acc_q;

	sdh_div #(.NW(ACC_W), .DW(WW)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (weight_q),
		.done   (div_done),
		.quot   (div_q),
		.rem_nz (div_rem_nz)
	);

	// The mean is offset from the smallest value; a negative result with a
	// remainder moves one step toward zero.
	assign mean_sum = {{3{vmin_q[31]}}, vmin_q} + {1'b0, div_q[33:0]};
	assign mean_fix = (mean_sum[34] && div_rem_nz) ? mean_sum + 35'd1 : mean_sum;
	assign var_sat  = (|div_q[ACC_W-1:64]) ? '1 : div_q[63:0];
	assign trial    = res_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			used_q      <= '0;
			total_q     <= '0;
			idx_q       <= '0;
			pos_q       <= '0;
			sample_q    <= '0;
			ack_kind_q  <= KIND_ACK;
			vmin_q      <= '0;
			mean_q      <= '0;
			weight_q    <= '0;
			acc_q       <= '0;
			prod_q      <= '0;
			sq_q        <= '0;
			rad_q       <= '0;
			res_q       <= '0;
			bit_q       <= '0;
			res_valid_q <= 1'b0;
			kind_q      <= KIND_ACK;
			entry_q     <= '0;
			count_q     <= '0;
			prop_q      <= '0;
			mean_out_q  <= '0;
			sd_q        <= '0;
			last_q      <= 1'b0;
		end else begin
			if (result_ch.ready && !emit_now) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (sample_ch.valid) begin
						sample_q   <= sample_ch.sample_value;
						idx_q      <= '0;
						ack_kind_q <= KIND_ACK;
						unique case (sample_ch.mode)
							MODE_INSERT: state_q <= S_SEARCH;
							MODE_REPORT: begin
								weight_q <= '0;
								acc_q    <= '0;
								mean_q   <= '0;
								res_q    <= '0;
								state_q  <= (used_q == '0) ? S_SUMMARY : S_SUM;
							end
							MODE_CLEAR: begin
								used_q  <= '0;
								total_q <= '0;
								state_q <= S_ACK;
							end
							default: state_q <= S_ACK;
						endcase
					end
				end
				S_SEARCH: begin
					if (idx_q < used_q && $signed(rd_val) < $signed(sample_q)) begin
						idx_q <= idx_q + IDX_W'(1);
					end else if (idx_q < used_q && rd_val == sample_q) begin
						if (total_q != '1) total_q <= total_q + 32'd1;
						state_q <= S_ACK;
					end else if (used_q >= IDX_W'(TABLE_DEPTH)) begin
						ack_kind_q <= KIND_DROP;
						state_q    <= S_ACK;
					end else begin
						pos_q   <= idx_q;
						idx_q   <= used_q;
						state_q <= S_SHIFT;
					end
				end
				S_SHIFT: begin
					if (idx_q == pos_q) begin
						used_q  <= used_q + IDX_W'(1);
						if (total_q != '1) total_q <= total_q + 32'd1;
						state_q <= S_ACK;
					end else begin
						idx_q <= idx_m1;
					end
				end
				S_ACK: begin
					if (can_emit) begin
						res_valid_q <= 1'b1;
						kind_q      <= ack_kind_q;
						entry_q     <= '0;
						count_q     <= '0;
						prop_q      <= '0;
						mean_out_q  <= '0;
						sd_q        <= '0;
						last_q      <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				S_SUM: begin
					weight_q <= weight_q + WW'(rd_cnt);
					if (idx_q == '0) vmin_q <= rd_val;
					prod_q  <= mul_p;
					state_q <= S_SUM_ADD;
				end
				S_SUM_ADD: begin
					acc_q <= acc_q + ACC_W'(prod_q);
					if (is_last) begin
						idx_q   <= '0;
						state_q <= S_ENT;
					end else begin
						idx_q   <= idx_q + IDX_W'(1);
						state_q <= S_SUM;
					end
				end
				S_ENT: state_q <= S_ENT_WAIT;
				S_ENT_WAIT: begin
					if (div_done) state_q <= S_ENT_EMIT;
				end
				S_ENT_EMIT: begin
					if (can_emit) begin
						res_valid_q <= 1'b1;
						kind_q      <= KIND_ENTRY;
						entry_q     <= rd_val;
						count_q     <= rd_cnt;
						prop_q      <= div_q[PROP_W-1:0];
						mean_out_q  <= '0;
						sd_q        <= '0;
						last_q      <= 1'b0;
						if (is_last) begin
							state_q <= S_MEAN;
						end else begin
							idx_q   <= idx_q + IDX_W'(1);
							state_q <= S_ENT;
						end
					end
				end
				S_MEAN: state_q <= S_MEAN_WAIT;
				S_MEAN_WAIT: begin
					if (div_done) begin
						mean_q  <= mean_fix[31:0];
						acc_q   <= '0;
						idx_q   <= '0;
						state_q <= S_SQ;
					end
				end
				S_SQ: begin
					prod_q  <= mul_p;
					state_q <= S_PLO;
				end
				S_PLO: begin
					sq_q    <= prod_q;
					prod_q  <= mul_p;
					state_q <= S_PHI;
				end
				S_PHI: begin
					acc_q   <= acc_q + ACC_W'(prod_q);
					prod_q  <= mul_p;
					state_q <= S_PACC;
				end
				S_PACC: begin
					acc_q <= acc_q + (ACC_W'(prod_q) << 33);
					if (is_last) begin
						state_q <= S_VAR;
					end else begin
						idx_q   <= idx_q + IDX_W'(1);
						state_q <= S_SQ;
					end
				end
				S_VAR: state_q <= S_VAR_WAIT;
				S_VAR_WAIT: begin
					if (div_done) begin
						rad_q   <= var_sat;
						res_q   <= '0;
						bit_q   <= 64'd1 << 62;
						state_q <= S_SQRT;
					end
				end
				S_SQRT: begin
					// Digit-by-digit square root, two radicand bits per step.
					if (bit_q == '0) begin
						state_q <= S_SUMMARY;
					end else begin
						if (rad_q >= trial) begin
							rad_q <= rad_q - trial;
							res_q <= (res_q >> 1) + bit_q;
						end else begin
							res_q <= res_q >> 1;
						end
						bit_q <= bit_q >> 2;
					end
				end
				S_SUMMARY: begin
					if (can_emit) begin
						res_valid_q <= 1'b1;
						kind_q      <= KIND_SUMMARY;
						entry_q     <= '0;
						count_q     <= total_q;
						prop_q      <= '0;
						mean_out_q  <= mean_q;
						sd_q        <= (|res_q[63:31]) ? '1 : res_q[SD_W-1:0];
						last_q      <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign sample_ch.ready         = (state_q == S_IDLE);
	assign result_ch.valid         = res_valid_q;
	assign result_ch.kind          = kind_q;
	assign result_ch.entry_value   = entry_q;
	assign result_ch.count         = count_q;
	assign result_ch.proportion    = prop_q;
	assign result_ch.mean          = mean_out_q;
	assign result_ch.std_deviation = sd_q;
	assign result_ch.last          = last_q;

	`SDH_ASSERT_NOW(a_used_bound, 1'b1, used_q <= IDX_W'(TABLE_DEPTH), "entry count above depth")
	`SDH_ASSERT_NEXT(a_busy_after_accept, sample_ch.valid && sample_ch.ready, !sample_ch.ready, "ready after accept")
	`SDH_ASSERT_NOW(a_entry_not_last, result_ch.valid && result_ch.kind == KIND_ENTRY, !result_ch.last, "entry marked last")
	`SDH_ASSERT_NOW(a_div_done_state, div_done, state_q == S_ENT_WAIT || state_q == S_MEAN_WAIT || state_q == S_VAR_WAIT, "divider finished unawaited")
endmodule
